[hw/rtl/rational_arith_unit_macros.svh]
// Assertion macros used by the rational arithmetic unit controller.
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RAU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/rau_pkg.sv]
// Types and constants shared by the rational arithmetic unit modules.
package rau_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FORM,
        ST_PREP,
        ST_GCD,
        ST_DIV,
        ST_FIN
    } t_state;

    // which cross product the shared multiplier forms
    typedef enum logic [1:0] {
        MS_NUM_A = 2'd0,
        MS_NUM_B = 2'd1,
        MS_DEN   = 2'd2
    } t_mul_sel;

    localparam int MUL_STEPS = 3;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     form;
        logic     prep;
        logic     gcd_step;
        logic     div_init;
        logic     div_step;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic reduce;
        logic gcd_done;
    } t_sts;

endpackage

[hw/rtl/rational_arith_unit.sv]
// Top level of the rational arithmetic unit: fraction add, sub, mul, div with reduction.
//
//  channel  dir  tdata fields, low bit first
//  s_axis   in   operation[1:0], left_num, left_den, right_num, right_den (W each), zero pad
//  m_axis   out  result_num, result_den (2W+1 each), zero pad
//
//  One item at a time. Accept, three cross products on one shared multiplier, form, prep.
//  No reduction: the raw fraction goes to the output register and m_axis_tvalid rises.
//  Reduction: binary gcd, then a bit-serial divide of both lanes by the gcd
//  over 2W+1 quotient bits before the result is loaded.
//  Result sits in an output register; the next item is taken while it waits,
//  and stalls in its last step until the sink takes the earlier result.
//  Reset is synchronous, active low; it drops any item in flight and any pending result.
module rational_arith_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // operation, left_num, left_den, right_num, right_den
    input  logic [((4*OPERAND_WIDTH+2+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // result_num, result_den
    output logic [((4*OPERAND_WIDTH+2+7)/8)*8-1:0] m_axis_tdata
);

    localparam int W  = OPERAND_WIDTH;
    localparam int RW = 2 * W + 1;
    localparam int DW = ((4 * W + 2 + 7) / 8) * 8;

    t_cmd w_cmd;
    t_sts w_sts;
    logic signed [RW-1:0] w_res_num, w_res_den;

    rau_ctrl #(
        .RES_WIDTH (RW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    rau_dp #(
        .W (W)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_operation  (s_axis_tdata[1:0]),
        .i_left_num   (s_axis_tdata[2+W-1:2]),
        .i_left_den   (s_axis_tdata[2+2*W-1:2+W]),
        .i_right_num  (s_axis_tdata[2+3*W-1:2+2*W]),
        .i_right_den  (s_axis_tdata[2+4*W-1:2+3*W]),
        .o_result_num (w_res_num),
        .o_result_den (w_res_den)
    );

    assign m_axis_tdata = DW'({w_res_den, w_res_num});

endmodule

[hw/rtl/rau_dp.sv]
// Datapath: shared multiplier, raw fraction, binary gcd and two-lane divider.
module rau_dp
    import rau_pkg::*;
#(
    parameter int W = 16
) (
    input  logic                  i_clk,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [1:0]            i_operation,
    input  logic signed [W-1:0]   i_left_num,
    input  logic signed [W-1:0]   i_left_den,
    input  logic signed [W-1:0]   i_right_num,
    input  logic signed [W-1:0]   i_right_den,
    output logic signed [2*W:0]   o_result_num,
    output logic signed [2*W:0]   o_result_den
);

    localparam int PW = 2 * W;
    localparam int RW = 2 * W + 1;

    t_op                 r_op;
    logic signed [W-1:0] r_ln, r_ld, r_rn, r_rd;
    logic signed [PW-1:0] r_pa, r_pb, r_pd;
    logic signed [RW-1:0] r_n, r_d;
    logic                r_neg_n, r_neg_d, r_reduce;
    logic [RW-1:0]       r_a, r_b, r_xn, r_xd, r_div, r_rem_n, r_rem_d;
    logic signed [RW-1:0] r_res_num, r_res_den;

    logic signed [W-1:0]  w_mul_a, w_mul_b;
    logic signed [PW-1:0] w_prod;
    logic [RW-1:0]        w_mag_n, w_mag_d;
    logic [RW-1:0]        n_a, n_b, n_xn, n_xd;
    logic [RW-1:0]        w_diff_ab, w_diff_ba;
    logic                 w_a_ge_b;
    logic [RW:0]          w_tn, w_td, w_subn, w_subd;
    logic                 w_qbit_n, w_qbit_d;
    logic [RW-1:0]        w_qn_s, w_qd_s;

    // operand selection for the shared multiplier
    always_comb begin
        w_mul_a = r_ld;
        w_mul_b = r_rd;
        unique case (i_cmd.mul_sel)
            MS_NUM_A: begin
                w_mul_a = (r_op == OP_ADD || r_op == OP_MUL) ? r_rn : r_rd;
                w_mul_b = (r_op == OP_ADD) ? r_ld : r_ln;
            end
            MS_NUM_B: begin
                w_mul_a = (r_op == OP_ADD) ? r_rd : r_ld;
                w_mul_b = (r_op == OP_ADD) ? r_ln : r_rn;
            end
            MS_DEN: begin
                w_mul_a = r_ld;
                w_mul_b = (r_op == OP_DIV) ? r_rn : r_rd;
            end
            default: begin
                w_mul_a = r_ld;
                w_mul_b = r_rd;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    assign w_mag_n = r_n[RW-1] ? (~r_n + RW'(1)) : r_n;
    assign w_mag_d = r_d[RW-1] ? (~r_d + RW'(1)) : r_d;

    // binary gcd step; common factors of two come off the dividends too
    assign w_diff_ab = r_a - r_b;
    assign w_diff_ba = r_b - r_a;
    assign w_a_ge_b  = (r_a >= r_b);

    always_comb begin
        n_a  = r_a;
        n_b  = r_b;
        n_xn = r_xn;
        n_xd = r_xd;
        priority if (!r_a[0] && !r_b[0]) begin
            n_a  = r_a >> 1;
            n_b  = r_b >> 1;
            n_xn = r_xn >> 1;
            n_xd = r_xd >> 1;
        end else if (!r_a[0]) begin
            n_a = r_a >> 1;
        end else if (!r_b[0]) begin
            n_b = r_b >> 1;
        end else if (w_a_ge_b) begin
            n_a = w_diff_ab >> 1;
        end else begin
            n_b = w_diff_ba >> 1;
        end
    end

    // restoring division, one quotient bit per lane per cycle
    assign w_tn     = {r_rem_n, r_xn[RW-1]};
    assign w_td     = {r_rem_d, r_xd[RW-1]};
    assign w_subn   = w_tn - {1'b0, r_div};
    assign w_subd   = w_td - {1'b0, r_div};
    assign w_qbit_n = !w_subn[RW];
    assign w_qbit_d = !w_subd[RW];

    assign w_qn_s = r_neg_n ? (~r_xn + RW'(1)) : r_xn;
    assign w_qd_s = r_neg_d ? (~r_xd + RW'(1)) : r_xd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= t_op'(i_operation);
            r_ln <= i_left_num;
            r_ld <= i_left_den;
            r_rn <= i_right_num;
            r_rd <= i_right_den;
        end
        if (i_cmd.mul_en) begin
            unique case (i_cmd.mul_sel)
                MS_NUM_A: r_pa <= w_prod;
                MS_NUM_B: r_pb <= w_prod;
                MS_DEN:   r_pd <= w_prod;
                default:  r_pd <= w_prod;
            endcase
        end
        if (i_cmd.form) begin
            unique case (r_op)
                OP_ADD:  r_n <= RW'(r_pa) + RW'(r_pb);
                OP_SUB:  r_n <= RW'(r_pa) - RW'(r_pb);
                default: r_n <= RW'(r_pa);
            endcase
            r_d <= RW'(r_pd);
        end
        if (i_cmd.prep) begin
            r_neg_n  <= r_n[RW-1];
            r_neg_d  <= r_d[RW-1];
            // reduce only when max(n, d) >= 2
            r_reduce <= (!r_n[RW-1] && (r_n[RW-1:1] != '0)) ||
                        (!r_d[RW-1] && (r_d[RW-1:1] != '0));
            r_a  <= w_mag_n;
            r_b  <= w_mag_d;
            r_xn <= w_mag_n;
            r_xd <= w_mag_d;
        end
        if (i_cmd.gcd_step) begin
            r_a  <= n_a;
            r_b  <= n_b;
            r_xn <= n_xn;
            r_xd <= n_xd;
        end
        if (i_cmd.div_init) begin
            r_div   <= (r_a == '0) ? r_b : r_a;
            r_rem_n <= '0;
            r_rem_d <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem_n <= w_qbit_n ? w_subn[RW-1:0] : w_tn[RW-1:0];
            r_rem_d <= w_qbit_d ? w_subd[RW-1:0] : w_td[RW-1:0];
            r_xn    <= {r_xn[RW-2:0], w_qbit_n};
            r_xd    <= {r_xd[RW-2:0], w_qbit_d};
        end
        if (i_cmd.out_load) begin
            r_res_num <= r_reduce ? $signed(w_qn_s) : r_n;
            r_res_den <= r_reduce ? $signed(w_qd_s) : r_d;
        end
    end

    assign o_sts.reduce   = r_reduce;
    assign o_sts.gcd_done = (r_a == '0) || (r_b == '0);
    assign o_result_num   = r_res_num;
    assign o_result_den   = r_res_den;

endmodule

[hw/rtl/rau_ctrl.sv]
// Controller: sequences multiply, reduce and divide, owns the handshakes.
module rau_ctrl
    import rau_pkg::*;
#(
    parameter int RES_WIDTH = 33
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_valid,
    output logic o_s_ready,
    output logic o_m_valid,
    input  logic i_m_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    `include "rational_arith_unit_macros.svh"

    localparam int CW = $clog2(RES_WIDTH);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    t_cmd          w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        w_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    w_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = t_mul_sel'(r_cnt[1:0]);
                if (r_cnt == CW'(MUL_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_FORM;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            ST_FORM: begin
                w_cmd.form = 1'b1;
                n_state    = ST_PREP;
            end
            ST_PREP: begin
                w_cmd.prep = 1'b1;
                n_state    = ST_GCD;
            end
            ST_GCD: begin
                priority if (!i_sts.reduce) begin
                    n_state = ST_FIN;
                end else if (i_sts.gcd_done) begin
                    w_cmd.div_init = 1'b1;
                    n_cnt          = '0;
                    n_state        = ST_DIV;
                end else begin
                    w_cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV: begin
                w_cmd.div_step = 1'b1;
                if (r_cnt == CW'(RES_WIDTH - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            ST_FIN: begin
                // wait for the output register to free up
                if (!r_out_valid || i_m_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = w_cmd.out_load ? 1'b1 : (r_out_valid && !i_m_ready);
    end

    assign o_cmd     = w_cmd;
    assign o_m_valid = r_out_valid;

    `RAU_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load, (!r_out_valid || i_m_ready), "pending result overwritten")
    `RAU_ASSERT_NXT(a_accept_to_mul, i_clk, i_rst_n, (i_s_valid && o_s_ready), (r_state == ST_MUL && r_cnt == '0), "accepted item did not start multiply")
    `RAU_ASSERT_IMP(a_gcd_stops, i_clk, i_rst_n, w_cmd.gcd_step, (!i_sts.gcd_done && i_sts.reduce), "gcd stepped after finishing")
    `RAU_ASSERT_IMP(a_div_bound, i_clk, i_rst_n, (r_state == ST_DIV), (r_cnt <= CW'(RES_WIDTH - 1)), "divider ran past its bit count")

endmodule
